// ===== hdl/hkoc_pkg.sv =====
package hkoc_pkg;

    localparam int HASH_W = 13;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_NEW    = 2'd0,
        ST_FOUND  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        logic clr_step;
        logic key_wr;
        logic chk_free;
        logic way_next;
        logic idx_first;
        logic idx_inc;
        logic hit_wr;
        logic ins_wr;
        logic copy_wr;
        logic res_reject;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic too_long;
        logic cand;
        logic free_now;
        logic have_free;
        logic way_last;
        logic letter_eq;
        logic idx_last;
        logic out_busy;
    } t_sts;

    // (h * 33 + letter) mod b, as a chain of compare-subtract steps; h < b, 16 <= b <= 4096
    function automatic logic [HASH_W-1:0] f_hash_step(
        input logic [HASH_W-1:0] h,
        input logic [4:0]        letter,
        input logic [HASH_W-1:0] b
    );
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] l;
        x = h;
        for (int k = 0; k < 5; k++) begin
            x = {x[HASH_W-2:0], 1'b0};
            if (x >= b) x = x - b;
        end
        x = x + h;
        if (x >= b) x = x - b;
        l = HASH_W'(letter);
        if (l >= b) l = l - b;
        x = x + l;
        if (x >= b) x = x - b;
        return x;
    endfunction

endpackage

// ===== hdl/hkoc_ctrl.sv =====
module hkoc_ctrl
    import hkoc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_letter,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_CLR  = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_RD   = 10'b00_0000_0100,
        S_CHK  = 10'b00_0000_1000,
        S_CMPL = 10'b00_0001_0000,
        S_HIT  = 10'b00_0010_0000,
        S_INS  = 10'b00_0100_0000,
        S_COPY = 10'b00_1000_0000,
        S_OUT  = 10'b01_0000_0000,
        S_REJ  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.key_wr = 1'b1;
                    if (i_last_letter) n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk_free  = 1'b1;
                o_cmd.idx_first = 1'b1;
                if (i_sts.too_long) begin
                    n_state = S_REJ;
                end else if (i_sts.cand) begin
                    n_state = S_CMPL;
                end else if (i_sts.way_last) begin
                    n_state = (i_sts.have_free || i_sts.free_now) ? S_INS : S_REJ;
                end else begin
                    o_cmd.way_next = 1'b1;
                    n_state = S_RD;
                end
            end
            S_CMPL: begin
                if (!i_sts.letter_eq) begin
                    if (i_sts.way_last) begin
                        n_state = i_sts.have_free ? S_INS : S_REJ;
                    end else begin
                        o_cmd.way_next = 1'b1;
                        n_state = S_RD;
                    end
                end else if (i_sts.idx_last) begin
                    n_state = S_HIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_HIT: begin
                o_cmd.hit_wr = 1'b1;
                n_state = S_OUT;
            end
            S_INS: begin
                o_cmd.ins_wr    = 1'b1;
                o_cmd.idx_first = 1'b1;
                n_state = S_COPY;
            end
            S_COPY: begin
                o_cmd.copy_wr = 1'b1;
                if (i_sts.idx_last) n_state = S_OUT;
                else o_cmd.idx_inc = 1'b1;
            end
            S_REJ: begin
                o_cmd.res_reject = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else r_state <= n_state;
    end

endmodule

// ===== hdl/hkoc_datapath.sv =====
module hkoc_datapath
    import hkoc_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4,
    parameter int MAX_KEY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_letter,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_repeat_count
);

    localparam int BW   = $clog2(BUCKETS);
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KIW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int LW   = $clog2(MAX_KEY + 1);
    localparam int SW   = BW + WW;
    localparam int AW   = SW + KIW;
    localparam int SEED = 5381 % BUCKETS;

    // table memories
    logic [WAYS-1:0] m_valid [BUCKETS];
    logic [LW-1:0]   m_len   [2**SW];
    logic [15:0]     m_cnt   [2**SW];
    logic [4:0]      m_let   [2**AW];
    logic [4:0]      m_kbuf  [2**KIW];

    logic [WAYS-1:0] r_vrow;
    logic [LW-1:0]   r_mlen;
    logic [15:0]     r_mcnt;
    logic [4:0]      r_let;
    logic [4:0]      r_kq;

    logic [BW-1:0]   r_hash;
    logic [LW-1:0]   r_len;
    logic            r_too_long;
    logic [WW-1:0]   r_way;
    logic [WW-1:0]   r_free;
    logic            r_have_free;
    logic [KIW-1:0]  r_idx;
    logic [BW-1:0]   r_clr;
    t_status         r_res_status;
    logic [15:0]     r_res_count;
    logic            r_out_valid;
    t_status         r_out_status;
    logic [15:0]     r_out_count;

    logic [KIW-1:0]  rd_idx;
    logic [BW-1:0]   hash_next;
    logic [15:0]     cnt_inc;
    logic            key_full;

    assign rd_idx    = i_cmd.idx_first ? '0 : r_idx + KIW'(1);
    assign hash_next = BW'(f_hash_step(HASH_W'(r_hash), i_letter, HASH_W'(BUCKETS)));
    assign cnt_inc   = (r_mcnt == COUNT_MAX) ? COUNT_MAX : r_mcnt + 16'd1;
    assign key_full  = r_too_long || (r_len >= LW'(MAX_KEY));

    always_ff @(posedge i_clk) begin
        r_vrow <= m_valid[r_hash];
        r_mlen <= m_len[{r_hash, r_way}];
        r_mcnt <= m_cnt[{r_hash, r_way}];
        r_let  <= m_let[{r_hash, r_way, rd_idx}];
        r_kq   <= m_kbuf[rd_idx];
        if (i_cmd.clr_step) m_valid[r_clr] <= '0;
        else if (i_cmd.ins_wr) m_valid[r_hash] <= r_vrow | (WAYS'(1) << r_free);
        if (i_cmd.hit_wr) m_cnt[{r_hash, r_way}] <= cnt_inc;
        else if (i_cmd.ins_wr) m_cnt[{r_hash, r_free}] <= '0;
        if (i_cmd.ins_wr) m_len[{r_hash, r_free}] <= r_len;
        if (i_cmd.copy_wr) m_let[{r_hash, r_free, r_idx}] <= r_kq;
        if (i_cmd.key_wr && !key_full) m_kbuf[r_len[KIW-1:0]] <= i_letter;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_wr) begin
            r_res_status <= ST_FOUND;
            r_res_count  <= cnt_inc;
        end else if (i_cmd.ins_wr) begin
            r_res_status <= ST_NEW;
            r_res_count  <= '0;
        end else if (i_cmd.res_reject) begin
            r_res_status <= ST_REJECT;
            r_res_count  <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_count  <= r_res_count;
        end
        if (i_cmd.idx_first) r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + KIW'(1);
        if (i_cmd.chk_free && !r_vrow[r_way] && !r_have_free) r_free <= r_way;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= BW'(SEED);
            r_len       <= '0;
            r_too_long  <= 1'b0;
            r_way       <= '0;
            r_have_free <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + BW'(1);
            if (i_cmd.key_wr) begin
                if (key_full) begin
                    r_too_long <= 1'b1;
                end else begin
                    r_len  <= r_len + LW'(1);
                    r_hash <= hash_next;
                end
            end
            if (i_cmd.way_next) r_way <= r_way + WW'(1);
            if (i_cmd.chk_free && !r_vrow[r_way]) r_have_free <= 1'b1;
            if (i_cmd.out_load) begin
                r_hash      <= BW'(SEED);
                r_len       <= '0;
                r_too_long  <= 1'b0;
                r_way       <= '0;
                r_have_free <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last  = (r_clr == BW'(BUCKETS - 1));
    assign o_sts.too_long  = r_too_long;
    assign o_sts.cand      = r_vrow[r_way] && (r_mlen == r_len);
    assign o_sts.free_now  = !r_vrow[r_way];
    assign o_sts.have_free = r_have_free;
    assign o_sts.way_last  = (r_way == WW'(WAYS - 1));
    assign o_sts.letter_eq = (r_let == r_kq);
    assign o_sts.idx_last  = (r_idx == KIW'(r_len - LW'(1)));
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_repeat_count = r_out_count;

endmodule

// ===== hdl/hashed_key_occurrence_counter.sv =====
// Counts occurrences of keys sent one lowercase letter per request, last letter flagged.
// A running hash (seed 5381, times 33 plus letter, mod BUCKETS) picks a bucket of WAYS
// entries; a new key is stored with status new, a known key returns its previous count
// plus one (saturating at 65535), and an over-long key or a full bucket is rejected.
// Sequence: a non-final letter is taken and the input stays open. A final letter starts a
// search that reads and checks the ways of the bucket in turn, comparing the letters one by
// one for each way whose stored length matches; then a hit or a rejection is recorded, or a
// new key is written and its letters copied one by one, and the result is loaded into the
// output register, later while the previous result is still stalled; an over-long key is
// rejected after a single visit. This is set by the single read port of the table
// memories. After reset a clearing pass wipes all valid bits; no letter is taken during it.
module hashed_key_occurrence_counter
    import hkoc_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4,
    parameter int MAX_KEY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [4:0]  i_letter,
    input  logic        i_last_letter,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_repeat_count
);

    t_cmd cmd;
    t_sts sts;

    hkoc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_letter (i_last_letter),
        .i_sts         (sts),
        .o_in_ready    (o_in_ready),
        .o_cmd         (cmd)
    );

    hkoc_datapath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .MAX_KEY (MAX_KEY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_letter       (i_letter),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_repeat_count (o_repeat_count)
    );

endmodule

// ===== hdl/hkoc_checker.sv =====
module hkoc_checker
    import hkoc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last_letter,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_repeat_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_repeat_count))
        else $error("result dropped or changed while stalled");

    // a final letter starts a table search, so the input closes for a while
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_letter |=> !o_in_ready)
        else $error("input open right after a final letter");

    a_open_after_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_last_letter |=> o_in_ready)
        else $error("input closed after a non-final letter");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_FOUND) |-> o_repeat_count == 16'd0)
        else $error("nonzero count on a new or rejected key");

endmodule

bind hashed_key_occurrence_counter hkoc_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_last_letter  (i_last_letter),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_repeat_count (o_repeat_count)
);

// ===== bench/hashed_key_occurrence_counter_test.sv =====
`timescale 1ns / 100ps

module hashed_key_occurrence_counter_test;
    import hkoc_pkg::*;

    localparam int NB = 256;
    localparam int NW = 4;
    localparam int MK = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [4:0]  i_letter = '0;
    logic        i_last_letter = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_repeat_count;

    hashed_key_occurrence_counter #(.BUCKETS(NB), .WAYS(NW), .MAX_KEY(MK)) i_dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [4:0]  cur_key [MK];
    int          cur_len;
    logic        cur_long;
    int          cur_hash;
    logic        tab_valid [NB*NW];
    logic [4:0]  tab_key   [NB*NW][MK];
    int          tab_len   [NB*NW];
    logic [15:0] tab_count [NB*NW];

    typedef struct packed {
        t_status     status;
        logic [15:0] cnt;
    } t_lookup;

    t_lookup pending_lookups[$];
    int errors = 0;
    int n_letters = 0, n_keys = 0, n_new = 0, n_hit = 0, n_rej = 0;
    int idle_cycles = 0;
    logic sender_on = 1'b1;

    // known keys for reuse
    logic [4:0] bank_key [64][MK];
    int         bank_len [64];
    int         bank_n = 0;

    function automatic void clear_key();
        cur_len = 0;
        cur_long = 1'b0;
        cur_hash = 5381 % NB;
    endfunction

    function automatic void predict_letter(logic [4:0] l, logic last);
        int base, fw;
        bit hit, eq;
        t_lookup r;
        if (cur_long || cur_len >= MK) cur_long = 1'b1;
        else begin
            cur_key[cur_len] = l;
            cur_len++;
            cur_hash = (cur_hash * 33 + l) % NB;
        end
        if (!last) return;
        r.status = ST_REJECT;
        r.cnt = '0;
        if (!cur_long) begin
            base = cur_hash * NW;
            fw = -1;
            hit = 0;
            for (int w = 0; w < NW && !hit; w++) begin
                if (tab_valid[base+w] && tab_len[base+w] == cur_len) begin
                    eq = 1;
                    for (int i = 0; i < cur_len; i++)
                        if (tab_key[base+w][i] != cur_key[i]) eq = 0;
                    if (eq) begin
                        hit = 1;
                        if (tab_count[base+w] != COUNT_MAX) tab_count[base+w]++;
                        r.status = ST_FOUND;
                        r.cnt = tab_count[base+w];
                    end
                end
                if (!hit && !tab_valid[base+w] && fw < 0) fw = w;
            end
            if (!hit && fw >= 0) begin
                tab_valid[base+fw] = 1'b1;
                tab_len[base+fw] = cur_len;
                for (int i = 0; i < cur_len; i++) tab_key[base+fw][i] = cur_key[i];
                tab_count[base+fw] = '0;
                r.status = ST_NEW;
            end
        end
        pending_lookups.push_back(r);
        clear_key();
    endfunction

    // sends one letter request; bursts and gaps on the sender side
    task automatic send_letter(logic [4:0] l, logic last);
        if (!sender_on) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            sender_on = 1'b1;
        end
        i_in_valid <= 1'b1;
        i_letter <= l;
        i_last_letter <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_letter(l, last);
        n_letters++;
        if (last) n_keys++;
        if ($urandom_range(0, 7) == 0) begin
            sender_on = 1'b0;
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_key(logic [4:0] k [MK], int real_len);
        for (int i = 0; i < real_len; i++)
            send_letter(i < MK ? k[i] : 5'($urandom_range(0, 31)), i == real_len - 1);
    endtask

    task automatic remember(logic [4:0] k [MK], int len);
        int s;
        if (bank_n < 64) begin
            s = bank_n;
            bank_n++;
        end else begin
            s = $urandom_range(0, 63);
        end
        bank_key[s] = k;
        bank_len[s] = len;
    endtask

    task automatic test_extremes();
        logic [4:0] k [MK];
        for (int i = 0; i < MK; i++) k[i] = 5'd25;
        k[0] = 5'd0;
        send_key(k, 1);       // single letter a, new
        send_key(k, 1);       // repeat
        k[0] = 5'd31;
        send_key(k, 1);       // code beyond z
        for (int i = 0; i < MK; i++) k[i] = 5'(i);
        send_key(k, MK);      // full length
        send_key(k, MK + 2);  // too long
    endtask

    // keys of length 3 that share one bucket: six of them overflow its four ways
    task automatic test_bucket_full();
        logic [4:0] k [MK];
        int h0, got;
        h0 = 5381 % NB;
        got = 0;
        for (int a = 0; a < 32 && got < 6; a++)
            for (int b = 0; b < 32 && got < 6; b++)
                for (int c = 0; c < 32 && got < 6; c++)
                    if ((((h0 * 33 + a) % NB * 33 + b) % NB * 33 + c) % NB == 7) begin
                        k[0] = 5'(a);
                        k[1] = 5'(b);
                        k[2] = 5'(c);
                        send_key(k, 3);
                        if (got == 0) send_key(k, 3);
                        got++;
                    end
    endtask

    task automatic test_random();
        logic [4:0] k [MK];
        int len, sel;
        while (n_letters < 600) begin
            sel = $urandom_range(0, 9);
            if (sel < 5 && bank_n > 0) begin
                len = $urandom_range(0, bank_n - 1);
                k = bank_key[len];
                send_key(k, bank_len[len]);
            end else begin
                len = (sel == 9) ? $urandom_range(MK - 1, MK + 3) : $urandom_range(1, 4);
                for (int i = 0; i < MK; i++)
                    k[i] = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 25));
                send_key(k, len);
                if (len <= MK) remember(k, len);
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 15) < 5) ? 1'b0 : ($urandom_range(0, 63) != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result status=%0d", o_status);
                errors++;
            end else begin
                t_lookup e;
                e = pending_lookups.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_repeat_count !== e.cnt) begin
                    $error("repeat_count: expected %0d, actual %0d", e.cnt, o_repeat_count);
                    errors++;
                end
                case (e.status)
                    ST_NEW:   n_new++;
                    ST_FOUND: n_hit++;
                    default:  n_rej++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NB * NW; i++) tab_valid[i] = 1'b0;
        clear_key();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_bucket_full();
        test_random();
        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d letters in %0d keys: %0d new, %0d repeats, %0d rejected",
                 n_letters, n_keys, n_new, n_hit, n_rej);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
